// ----- hw/rtl/zoom_envelope_mixer_macros.svh -----
// Assertion macros for the zoom envelope mixer.
// Assumes a clock named clk and a reset named rst in the including scope.
`ifndef ZOOM_ENVELOPE_MIXER_MACROS_SVH
`define ZOOM_ENVELOPE_MIXER_MACROS_SVH
`ifndef ASSERT_OFF
`define ZEM_ASSERT_IMPLY(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("zem: implication check failed");
`define ZEM_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("zem: next-cycle check failed");
`else
`define ZEM_ASSERT_IMPLY(lbl, ant, cons)
`define ZEM_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

// ----- hw/rtl/zem_pkg.sv -----
// Shared constants, preset ROM and controller/datapath interface types
// for the zoom envelope mixer. No dependencies.
package zem_pkg;

  localparam int MAX_SLOTS_DEF    = 4;
  localparam int PRESET_COUNT_DEF = 10;
  localparam int ROM_SIZE         = 10;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ADD_PUNCH = 3'd1;
  localparam logic [2:0] OP_SET_PUNCH = 3'd2;
  localparam logic [2:0] OP_ADD_PRE   = 3'd3;
  localparam logic [2:0] OP_SET_PRE   = 3'd4;
  localparam logic [2:0] OP_FADE      = 3'd5;
  localparam logic [2:0] OP_RESET     = 3'd6;

  typedef struct packed {
    logic load;
    logic clear;
    logic push_punch;
    logic preset_mul;
    logic push_preset;
    logic loop_init;
    logic w_start;
    logic div_step;
    logic sq_mul;
    logic cube_mul;
    logic w_final;
    logic tick_apply;
    logic fade_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       empty;
    logic       idx_bad;
    logic       dur_zero;
    logic       div_last;
    logic       slot_last;
    logic       out_free;
  } sts_t;

  function automatic logic [15:0] rom_amt(input logic [3:0] idx);
    case (idx)
      4'd0: rom_amt = 16'd1843;
      4'd1: rom_amt = 16'd2867;
      4'd2: rom_amt = 16'd3686;
      4'd3: rom_amt = 16'd5325;
      4'd4: rom_amt = 16'd6963;
      4'd5: rom_amt = 16'd4506;
      4'd6: rom_amt = 16'd8602;
      4'd7: rom_amt = 16'd3277;
      4'd8: rom_amt = 16'd5734;
      4'd9: rom_amt = 16'd2253;
      default: rom_amt = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] rom_att(input logic [3:0] idx);
    case (idx)
      4'd0: rom_att = 16'd205;
      4'd1: rom_att = 16'd184;
      4'd2: rom_att = 16'd184;
      4'd3: rom_att = 16'd205;
      4'd4: rom_att = 16'd225;
      4'd5: rom_att = 16'd225;
      4'd6: rom_att = 16'd246;
      4'd7: rom_att = 16'd205;
      4'd8: rom_att = 16'd225;
      4'd9: rom_att = 16'd184;
      default: rom_att = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] rom_rel(input logic [3:0] idx);
    case (idx)
      4'd0: rom_rel = 16'd492;
      4'd1: rom_rel = 16'd573;
      4'd2: rom_rel = 16'd614;
      4'd3: rom_rel = 16'd737;
      4'd4: rom_rel = 16'd819;
      4'd5: rom_rel = 16'd901;
      4'd6: rom_rel = 16'd1065;
      4'd7: rom_rel = 16'd696;
      4'd8: rom_rel = 16'd942;
      4'd9: rom_rel = 16'd451;
      default: rom_rel = 16'd0;
    endcase
  endfunction

endpackage

// ----- hw/rtl/zem_ctrl.sv -----
// Sequencer for the zoom envelope mixer: decodes operations and steps the
// per-slot weight loop. Depends on zem_pkg.
module zem_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  zem_pkg::sts_t sts,
  output zem_pkg::cmd_t cmd
);
  import zem_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_PMUL   = 4'd2;
  localparam logic [3:0] S_PPUSH  = 4'd3;
  localparam logic [3:0] S_WSTART = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_SQ     = 4'd6;
  localparam logic [3:0] S_CUBE   = 4'd7;
  localparam logic [3:0] S_WFIN   = 4'd8;
  localparam logic [3:0] S_APPLY  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_TICK: begin
            cmd.loop_init = 1'b1;
            state_next    = sts.empty ? S_OUT : S_WSTART;
          end
          OP_ADD_PUNCH: begin
            cmd.push_punch = 1'b1;
            state_next     = S_IDLE;
          end
          OP_SET_PUNCH: begin
            cmd.clear      = 1'b1;
            cmd.push_punch = 1'b1;
            state_next     = S_IDLE;
          end
          OP_ADD_PRE, OP_SET_PRE: begin
            state_next = sts.idx_bad ? S_IDLE : S_PMUL;
          end
          OP_FADE: begin
            if (sts.dur_zero) begin
              cmd.clear  = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.loop_init = 1'b1;
              state_next    = sts.empty ? S_IDLE : S_WSTART;
            end
          end
          OP_RESET: begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_PMUL: begin
        cmd.preset_mul = 1'b1;
        state_next     = S_PPUSH;
      end
      S_PPUSH: begin
        cmd.push_preset = 1'b1;
        cmd.clear       = (sts.op == OP_SET_PRE);
        state_next      = S_IDLE;
      end
      S_WSTART: begin
        cmd.w_start = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_mul = 1'b1;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube_mul = 1'b1;
        state_next   = S_WFIN;
      end
      S_WFIN: begin
        cmd.w_final = 1'b1;
        state_next  = S_APPLY;
      end
      S_APPLY: begin
        if (sts.op == OP_TICK) begin
          cmd.tick_apply = 1'b1;
          state_next     = sts.slot_last ? S_OUT : S_WSTART;
        end else begin
          cmd.fade_apply = 1'b1;
          state_next     = sts.slot_last ? S_IDLE : S_WSTART;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/zem_dp.sv -----
// Datapath of the zoom envelope mixer: slot storage, serial divider,
// smoothstep multiplies, accumulator and output register. Depends on zem_pkg.
module zem_dp #(
  parameter int MAX_SLOTS    = zem_pkg::MAX_SLOTS_DEF,
  parameter int PRESET_COUNT = zem_pkg::PRESET_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  zem_pkg::cmd_t      cmd,
  output zem_pkg::sts_t      sts,
  input  logic [2:0]         operation,
  input  logic signed [15:0] amount,
  input  logic [15:0]        attack_time,
  input  logic [15:0]        release_time,
  input  logic [3:0]         preset_index,
  input  logic signed [15:0] strength,
  input  logic [15:0]        duration,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] zoom_offset,
  output logic [2:0]         active_slots
);
  import zem_pkg::*;

  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int ACC_W = 34 + $clog2(MAX_SLOTS + 1);
  localparam int SH_W  = ACC_W - 16;
  localparam logic [1:0] M_ZERO = 2'd0;
  localparam logic [1:0] M_RISE = 2'd1;
  localparam logic [1:0] M_FALL = 2'd2;

  // slot storage
  logic signed [15:0] s_amt [MAX_SLOTS];
  logic [15:0]        s_att [MAX_SLOTS];
  logic [15:0]        s_rel [MAX_SLOTS];
  logic [15:0]        s_el  [MAX_SLOTS];
  logic [CW-1:0]      count;

  // latched item
  logic [2:0]         op_r;
  logic signed [15:0] amt_r;
  logic [15:0]        att_r, rel_r, dur_r;
  logic [3:0]         idx_r;
  logic signed [15:0] str_r;

  // loop and arithmetic
  logic [CW-1:0]            si, k;
  logic [1:0]               mode;
  logic [16:0]              rem;
  logic [15:0]              den, q;
  logic [3:0]               dcnt;
  logic [31:0]              tt;
  logic [49:0]              cube;
  logic [16:0]              w;
  logic signed [32:0]       pmul;
  logic signed [ACC_W-1:0]  acc;

  logic [IW-1:0]      sx;
  logic signed [15:0] c_amt;
  logic [15:0]        c_att, c_rel, c_el, u;
  logic [16:0]        r2, el_sum, endt;
  logic [15:0]        new_el;
  logic               dead;
  logic signed [33:0] prod;
  logic signed [17:0] fade_sh;
  logic signed [15:0] fade_amt;
  logic signed [20:0] pre_sh;
  logic signed [15:0] pre_amt;
  logic signed [SH_W-1:0] tick_sh;
  logic signed [17:0] tick_res;
  logic [50:0]        cube_rnd;
  logic [16:0]        sm;
  logic [CW-1:0]      base;
  logic               idx_bad;

  assign sx    = si[IW-1:0];
  assign c_amt = s_amt[sx];
  assign c_att = s_att[sx];
  assign c_rel = s_rel[sx];
  assign c_el  = s_el[sx];
  assign u     = c_el - c_att;

  assign r2 = {rem[15:0], 1'b0};

  assign el_sum = {1'b0, c_el} + {1'b0, dur_r};
  assign new_el = el_sum[16] ? 16'hFFFF : el_sum[15:0];
  assign endt   = {1'b0, c_att} + {1'b0, c_rel};
  assign dead   = ({1'b0, new_el} >= endt) || (new_el == 16'hFFFF);

  assign prod = 34'(c_amt) * 34'($signed({1'b0, w}));

  // round half up, then saturate
  assign fade_sh  = 18'((prod + 34'sd32768) >>> 16);
  assign fade_amt = (fade_sh > 18'sd32767)  ? 16'sh7FFF :
                    (fade_sh < -18'sd32768) ? 16'sh8000 : fade_sh[15:0];
  assign pre_sh   = 21'((pmul + 33'sd2048) >>> 12);
  assign pre_amt  = (pre_sh > 21'sd32767)  ? 16'sh7FFF :
                    (pre_sh < -21'sd32768) ? 16'sh8000 : pre_sh[15:0];
  assign tick_sh  = SH_W'((acc + ACC_W'(32768)) >>> 16);
  assign tick_res = (tick_sh > SH_W'(131071))   ? 18'sh1FFFF :
                    (tick_sh < -SH_W'(131072))  ? 18'sh20000 : tick_sh[17:0];

  assign cube_rnd = {1'b0, cube} + 51'h0_8000_0000;
  assign sm       = cube_rnd[48:32];

  assign base    = cmd.clear ? '0 : count;
  assign idx_bad = ({1'b0, idx_r} >= 5'(PRESET_COUNT)) || ({1'b0, idx_r} >= 5'(ROM_SIZE));

  assign sts.op        = op_r;
  assign sts.empty     = (count == '0);
  assign sts.idx_bad   = idx_bad;
  assign sts.dur_zero  = (dur_r == 16'd0);
  assign sts.div_last  = (dcnt == 4'd15);
  assign sts.slot_last = (si == count - CW'(1));
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= operation;
      amt_r <= amount;
      att_r <= attack_time;
      rel_r <= release_time;
      idx_r <= preset_index;
      str_r <= strength;
      dur_r <= duration;
    end
    if (cmd.preset_mul) pmul <= 33'($signed({1'b0, rom_amt(idx_r)})) * 33'(str_r);
    if (cmd.loop_init) acc <= '0;

    if (cmd.w_start) begin
      dcnt <= '0;
      q    <= '0;
      if (c_att == 16'd0 && c_rel == 16'd0) begin
        mode <= M_ZERO;
        rem  <= '0;
        den  <= 16'd1;
      end else if (c_att != 16'd0 && c_el < c_att) begin
        mode <= M_RISE;
        rem  <= {1'b0, c_el};
        den  <= c_att;
      end else if (c_rel == 16'd0 || u >= c_rel) begin
        mode <= M_ZERO;
        rem  <= '0;
        den  <= 16'd1;
      end else begin
        mode <= M_FALL;
        rem  <= {1'b0, u};
        den  <= c_rel;
      end
    end
    if (cmd.div_step) begin
      dcnt <= dcnt + 4'd1;
      if (r2 >= {1'b0, den}) begin
        rem <= r2 - {1'b0, den};
        q   <= {q[14:0], 1'b1};
      end else begin
        rem <= r2;
        q   <= {q[14:0], 1'b0};
      end
    end
    if (cmd.sq_mul) tt <= 32'(q) * 32'(q);
    if (cmd.cube_mul) cube <= 50'(tt) * 50'(18'd196608 - {1'b0, q, 1'b0});
    if (cmd.w_final) begin
      case (mode)
        M_RISE:  w <= sm;
        M_FALL:  w <= 17'd65536 - sm;
        default: w <= '0;
      endcase
    end

    if (cmd.tick_apply) begin
      acc <= acc + ACC_W'(prod);
      if (!dead) begin
        s_amt[k[IW-1:0]] <= c_amt;
        s_att[k[IW-1:0]] <= c_att;
        s_rel[k[IW-1:0]] <= c_rel;
        s_el[k[IW-1:0]]  <= new_el;
      end
    end
    if (cmd.fade_apply) begin
      s_amt[sx] <= fade_amt;
      s_att[sx] <= '0;
      s_rel[sx] <= dur_r;
      s_el[sx]  <= '0;
    end

    if (cmd.push_punch || cmd.push_preset) begin
      if (base == CW'(MAX_SLOTS)) begin
        // table full: drop the oldest
        for (int j = 0; j < MAX_SLOTS - 1; j++) begin
          s_amt[j] <= s_amt[j+1];
          s_att[j] <= s_att[j+1];
          s_rel[j] <= s_rel[j+1];
          s_el[j]  <= s_el[j+1];
        end
        s_amt[MAX_SLOTS-1] <= cmd.push_punch ? amt_r : pre_amt;
        s_att[MAX_SLOTS-1] <= cmd.push_punch ? att_r : rom_att(idx_r);
        s_rel[MAX_SLOTS-1] <= cmd.push_punch ? rel_r : rom_rel(idx_r);
        s_el[MAX_SLOTS-1]  <= '0;
      end else begin
        s_amt[base[IW-1:0]] <= cmd.push_punch ? amt_r : pre_amt;
        s_att[base[IW-1:0]] <= cmd.push_punch ? att_r : rom_att(idx_r);
        s_rel[base[IW-1:0]] <= cmd.push_punch ? rel_r : rom_rel(idx_r);
        s_el[base[IW-1:0]]  <= '0;
      end
    end

    if (cmd.out_load) begin
      zoom_offset  <= tick_res;
      active_slots <= 3'(count);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      si        <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.loop_init) begin
        si <= '0;
        k  <= '0;
      end
      if (cmd.tick_apply || cmd.fade_apply) si <= si + CW'(1);
      if (cmd.tick_apply) begin
        if (!dead) k <= k + CW'(1);
        if (sts.slot_last) count <= dead ? k : k + CW'(1);
      end
      if (cmd.push_punch || cmd.push_preset) begin
        count <= (base == CW'(MAX_SLOTS)) ? base : base + CW'(1);
      end else if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.out_load)       out_valid <= 1'b1;
      else if (!out_stall)    out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/zoom_envelope_mixer.sv -----
// Zoom envelope mixer: one item at a time, input stalled while busy.
// Tick and fade walk the live slots one at a time: per slot a 16-step serial
// divider, then square, cube, weight and apply steps. Punch, reset and zero
// fade end at decode; preset adds multiply and push; a held result delays a tick.
// rst (synchronous) empties all slots and drops any pending result.
// Depends on zem_pkg, zem_ctrl, zem_dp and the assertion macro header.
`include "zoom_envelope_mixer_macros.svh"
module zoom_envelope_mixer #(
  parameter int MAX_SLOTS    = zem_pkg::MAX_SLOTS_DEF,
  parameter int PRESET_COUNT = zem_pkg::PRESET_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [15:0] amount,
  input  logic [15:0]        attack_time,
  input  logic [15:0]        release_time,
  input  logic [3:0]         preset_index,
  input  logic signed [15:0] strength,
  input  logic [15:0]        duration,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] zoom_offset,
  output logic [2:0]         active_slots
);
  import zem_pkg::*;

  cmd_t cmd;
  sts_t sts;

  zem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  zem_dp #(
    .MAX_SLOTS    (MAX_SLOTS),
    .PRESET_COUNT (PRESET_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .amount       (amount),
    .attack_time  (attack_time),
    .release_time (release_time),
    .preset_index (preset_index),
    .strength     (strength),
    .duration     (duration),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .zoom_offset  (zoom_offset),
    .active_slots (active_slots)
  );

  `ZEM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ZEM_ASSERT_IMPLY(a_result_from_tick, cmd.out_load, sts.op == OP_TICK)
  `ZEM_ASSERT_IMPLY(a_slots_in_range, out_valid, active_slots <= MAX_SLOTS)

endmodule
